// ===== rtl/lgps_pkg.sv =====
package lgps_pkg;

  localparam int MAX_STOPS  = 16;
  localparam int COORD_BITS = 12;
  localparam int STOP_AW    = $clog2(MAX_STOPS);

  // coef * (2*coord + 1), signed
  localparam int PROD_W = 32 + COORD_BITS + 2;
  localparam int SUM_W  = PROD_W + 2;
  localparam int GX_W   = SUM_W - 1;
  localparam int FRAC_W = 16;
  localparam int POS_W  = FRAC_W + 1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  localparam logic [1:0] TILE_CLAMP  = 2'd0;
  localparam logic [1:0] TILE_REPEAT = 2'd1;
  localparam logic [1:0] TILE_MIRROR = 2'd2;

  typedef enum logic [2:0] {
    CFG_COEF_X      = 3'd0,
    CFG_COEF_Y      = 3'd1,
    CFG_COEF_OFFSET = 3'd2,
    CFG_TILE_MODE   = 3'd3,
    CFG_COLOR_COUNT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] coef_x;
    logic signed [31:0] coef_y;
    logic signed [31:0] coef_offset;
    logic [1:0]         tile_mode;
    logic [4:0]         color_count;
  } cfg_t;

  typedef struct packed {
    logic                     is_wr;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic [3:0]               stop_idx;
    logic [31:0]              argb;
  } q_item_t;

endpackage

// ===== rtl/linear_gradient_pixel_shader_core.sv =====
// Linear gradient pixel shader.
// Input stream (in_*): in_tuser is the op, 0 loads a colour stop, 1 shades a
// pixel. in_tdata carries pix_x, pix_y, stop_index and the stop's alpha, red,
// green and blue. A shade gives one premultiplied ARGB pixel on out_*; a stop
// load gives nothing. Stops must be loaded before a shade reads them.
// Config port (cfg_*): write coef_x, coef_y, coef_offset, tile_mode and
// color_count by index while the block is idle; cfg_ready is always high.
// Throughput: one item per cycle unless out_tready stalls. An item passes
// the multiplier register, a four-entry queue and a seven stage shading
// pipeline whose stop table memory has a registered read.
// Reset clears the pipeline and queue and loads the register reset values;
// the stop table keeps whatever it held.
// When out_tready is low while a result waits, the shading pipeline holds,
// the queue fills, and in_tready drops once the queue and the input register
// are full; the result waiting on out_* stays until its transfer.
module linear_gradient_pixel_shader_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pix_x[11:0], pix_y[23:12], stop_index[27:24], stop_alpha[35:28],
  // stop_red[43:36], stop_green[51:44], stop_blue[59:52], zero pad
  input  logic [63:0] in_tdata,
  // op
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_argb[31:0]
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  lgps_pkg::cfg_t    cfg_r;
  logic              q_full, q_push, q_pop, q_valid;
  lgps_pkg::q_item_t push_item, q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_x      <= 32'sd65536;
      cfg_r.coef_y      <= '0;
      cfg_r.coef_offset <= '0;
      cfg_r.tile_mode   <= lgps_pkg::TILE_CLAMP;
      cfg_r.color_count <= 5'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lgps_pkg::CFG_COEF_X:      cfg_r.coef_x      <= cfg_data;
        lgps_pkg::CFG_COEF_Y:      cfg_r.coef_y      <= cfg_data;
        lgps_pkg::CFG_COEF_OFFSET: cfg_r.coef_offset <= cfg_data;
        lgps_pkg::CFG_TILE_MODE:   cfg_r.tile_mode   <= cfg_data[1:0];
        lgps_pkg::CFG_COLOR_COUNT: cfg_r.color_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  lgps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  lgps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_full   (q_full)
  );

  lgps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

// ===== rtl/lgps_ram.sv =====
module lgps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem_r[rd_addr_a];
      rd_data_b <= mem_r[rd_addr_b];
    end
  end

endmodule

// ===== rtl/lgps_front.sv =====
module lgps_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,
  input  logic              in_tuser,
  input  lgps_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              q_push,
  output lgps_pkg::q_item_t q_item
);

  logic                                      f_valid_r;
  lgps_pkg::q_item_t                         f_item_r;
  lgps_pkg::q_item_t                         f_item_nxt;
  logic                                      accept;
  logic [lgps_pkg::COORD_BITS-1:0]           pix_x;
  logic [lgps_pkg::COORD_BITS-1:0]           pix_y;

  assign in_tready = !f_valid_r || !q_full;
  assign q_push    = f_valid_r && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_item    = f_item_r;

  assign pix_x = lgps_pkg::COORD_BITS'(in_tdata[11:0]);
  assign pix_y = lgps_pkg::COORD_BITS'(in_tdata[23:12]);

  always_comb begin
    f_item_nxt.is_wr    = (in_tuser == lgps_pkg::OP_WRITE);
    f_item_nxt.prod_x   = cfg.coef_x * $signed({1'b0, pix_x, 1'b1});
    f_item_nxt.prod_y   = cfg.coef_y * $signed({1'b0, pix_y, 1'b1});
    f_item_nxt.stop_idx = in_tdata[27:24];
    f_item_nxt.argb     = {in_tdata[35:28], in_tdata[43:36], in_tdata[51:44], in_tdata[59:52]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (q_push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

// ===== rtl/lgps_queue.sv =====
module lgps_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lgps_pkg::q_item_t push_item,
  input  logic              pop,
  output logic              q_valid,
  output lgps_pkg::q_item_t q_item,
  output logic              q_full
);

  lgps_pkg::q_item_t              mem_r [lgps_pkg::QDEPTH];
  logic [lgps_pkg::QAW-1:0]       wr_ptr_r;
  logic [lgps_pkg::QAW-1:0]       rd_ptr_r;
  logic [lgps_pkg::QAW:0]         cnt_r;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == (lgps_pkg::QAW+1)'(lgps_pkg::QDEPTH));
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/lgps_back.sv =====
module lgps_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lgps_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  lgps_pkg::q_item_t q_item,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata
);

  localparam int AW = lgps_pkg::STOP_AW;

  function automatic logic [23:0] blend(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [15:0] t);
    logic signed [8:0]  d;
    logic signed [25:0] v;
    d = $signed({1'b0, c1}) - $signed({1'b0, c0});
    v = $signed({2'b00, c0, 16'h0000}) + $signed({1'b0, t}) * d;
    return v[23:0];
  endfunction

  // floor((prod + 255*2^31) / (255*2^32)) via reciprocal and one correction
  function automatic logic [7:0] div255(input logic [47:0] prod);
    logic [48:0] x;
    logic [16:0] y;
    logic [30:0] m;
    logic [8:0]  q0;
    logic [17:0] r;
    x  = {1'b0, prod} + (49'd255 << 31);
    y  = x[48:32];
    m  = (31'(y) << 14) + (31'(y) << 6);
    q0 = m[30:22];
    r  = 18'(y) - ((18'(q0) << 8) - 18'(q0));
    if (r >= 18'd255) begin
      q0 = q0 + 9'd1;
    end
    return q0[7:0];
  endfunction

  logic adv;

  // stage 1: position
  logic                          s1_valid_r, s1_wr_r;
  logic signed [lgps_pkg::GX_W-1:0] s1_gx_r;
  logic [3:0]                    s1_idx_r;
  logic [31:0]                   s1_argb_r;
  logic signed [lgps_pkg::SUM_W-1:0] sum;

  // stage 2: folded position
  logic                          s2_valid_r, s2_wr_r;
  logic [lgps_pkg::POS_W-1:0]    s2_f_r, f_nxt;
  logic [AW-1:0]                 s2_nm1_r, nm1_nxt;
  logic [3:0]                    s2_idx_r;
  logic [31:0]                   s2_argb_r;

  // stage 3: stop select
  logic                          s3_valid_r, s3_wr_r;
  logic [AW-1:0]                 s3_k_r, s3_k1_r, k_nxt, k1_nxt;
  logic [15:0]                   s3_t_r, t_nxt;
  logic [3:0]                    s3_idx_r;
  logic [31:0]                   s3_argb_r;
  logic [lgps_pkg::POS_W+AW-1:0] p;
  logic [AW:0]                   k_raw;

  // stage 4: stop colours from memory
  logic                          s4_valid_r;
  logic [15:0]                   s4_t_r;
  logic [31:0]                   c0, c1;
  logic                          ram_wr;

  // stage 5..7
  logic                          s5_valid_r;
  logic [23:0]                   s5_v_r [4];
  logic                          s6_valid_r;
  logic [47:0]                   s6_prod_r [3];
  logic [7:0]                    s6_alpha_r;
  logic [24:0]                   alpha_sum;
  logic                          s7_valid_r;
  logic [31:0]                   s7_data_r;

  assign adv        = !s7_valid_r || out_tready;
  assign q_pop      = adv && q_valid;
  assign out_tvalid = s7_valid_r;
  assign out_tdata  = s7_data_r;

  assign sum = lgps_pkg::SUM_W'(q_item.prod_x) + lgps_pkg::SUM_W'(q_item.prod_y)
             + (lgps_pkg::SUM_W'(cfg.coef_offset) <<< 1);

  always_comb begin
    case (cfg.tile_mode)
      lgps_pkg::TILE_REPEAT: f_nxt = {1'b0, s1_gx_r[15:0]};
      lgps_pkg::TILE_MIRROR: begin
        if (s1_gx_r[16:0] > 17'd65536) begin
          f_nxt = 17'd0 - s1_gx_r[16:0];
        end else begin
          f_nxt = s1_gx_r[16:0];
        end
      end
      default: begin
        if (s1_gx_r < 0) begin
          f_nxt = '0;
        end else if (s1_gx_r > 65536) begin
          f_nxt = 17'd65536;
        end else begin
          f_nxt = s1_gx_r[16:0];
        end
      end
    endcase
    if (cfg.color_count == 5'd0) begin
      nm1_nxt = '0;
    end else if (32'(cfg.color_count) > lgps_pkg::MAX_STOPS) begin
      nm1_nxt = AW'(lgps_pkg::MAX_STOPS - 1);
    end else begin
      nm1_nxt = AW'(cfg.color_count - 5'd1);
    end
  end

  always_comb begin
    p     = (lgps_pkg::POS_W+AW)'(s2_f_r) * (lgps_pkg::POS_W+AW)'(s2_nm1_r);
    k_raw = p[lgps_pkg::POS_W+AW-1:16];
    if (k_raw >= {1'b0, s2_nm1_r}) begin
      k_nxt = s2_nm1_r;
      t_nxt = '0;
    end else begin
      k_nxt = k_raw[AW-1:0];
      t_nxt = p[15:0];
    end
    k1_nxt = (k_nxt < s2_nm1_r) ? k_nxt + 1'b1 : k_nxt;
  end

  assign ram_wr = adv && s3_valid_r && s3_wr_r && (32'(s3_idx_r) < lgps_pkg::MAX_STOPS);

  lgps_ram #(
    .WIDTH(32),
    .DEPTH(lgps_pkg::MAX_STOPS)
  ) u_stop_ram (
    .clk      (clk),
    .wr_en    (ram_wr),
    .wr_addr  (AW'(s3_idx_r)),
    .wr_data  (s3_argb_r),
    .rd_en    (adv),
    .rd_addr_a(s3_k_r),
    .rd_addr_b(s3_k1_r),
    .rd_data_a(c0),
    .rd_data_b(c1)
  );

  assign alpha_sum = {1'b0, s5_v_r[3]} + 25'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      // colour stop writes end at the memory
      s4_valid_r <= s3_valid_r && !s3_wr_r;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
      s7_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_wr_r   <= q_item.is_wr;
      s1_gx_r   <= sum[lgps_pkg::SUM_W-1:1];
      s1_idx_r  <= q_item.stop_idx;
      s1_argb_r <= q_item.argb;

      s2_wr_r   <= s1_wr_r;
      s2_f_r    <= f_nxt;
      s2_nm1_r  <= nm1_nxt;
      s2_idx_r  <= s1_idx_r;
      s2_argb_r <= s1_argb_r;

      s3_wr_r   <= s2_wr_r;
      s3_k_r    <= k_nxt;
      s3_k1_r   <= k1_nxt;
      s3_t_r    <= t_nxt;
      s3_idx_r  <= s2_idx_r;
      s3_argb_r <= s2_argb_r;

      s4_t_r    <= s3_t_r;

      for (int i = 0; i < 4; i++) begin
        s5_v_r[i] <= blend(c0[8*i +: 8], c1[8*i +: 8], s4_t_r);
      end

      for (int i = 0; i < 3; i++) begin
        s6_prod_r[i] <= 48'(s5_v_r[i]) * 48'(s5_v_r[3]);
      end
      s6_alpha_r <= alpha_sum[23:16];

      s7_data_r <= {s6_alpha_r, div255(s6_prod_r[2]), div255(s6_prod_r[1]),
                    div255(s6_prod_r[0])};
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s3_valid_r) && $stable(s6_valid_r))
    else $error("back pipeline moved while output stalled");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s6_valid_r))
    else $error("result appeared without a pixel in flight");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s3_valid_r && s3_wr_r |=> !s4_valid_r)
    else $error("colour stop write produced a pixel");

endmodule

// ===== test/linear_gradient_pixel_shader_core_tb.sv =====
`timescale 1ns / 100ps

module linear_gradient_pixel_shader_core_tb;

  localparam int LATENCY   = 9;
  localparam int N_RANDOM  = 1150;
  localparam int MAX_CYCLE = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  linear_gradient_pixel_shader_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct packed {
    logic       op;
    logic [11:0] px;
    logic [11:0] py;
    logic [3:0]  idx;
    logic [31:0] argb;
  } shade_req_t;

  // shadow of the block's registers and colour stops
  logic signed [31:0] sh_cx = 32'sd65536;
  logic signed [31:0] sh_cy = '0;
  logic signed [31:0] sh_off = '0;
  logic [1:0]         sh_tile = lgps_pkg::TILE_CLAMP;
  logic [4:0]         sh_count = 5'd2;
  logic [31:0]        stops [lgps_pkg::MAX_STOPS];

  logic [31:0] pixel_q [$];
  int          failures = 0;
  int          cycle = 0;
  bit          no_idle = 1'b0;

  function automatic logic [7:0] premul(logic [63:0] v, logic [63:0] a);
    logic [127:0] num;
    num = 128'(v) * 128'(a) + (128'd255 << 31);
    return 8'(num / (128'd255 << 32));
  endfunction

  function automatic logic [31:0] shade_pixel(logic [11:0] px, logic [11:0] py);
    logic signed [63:0] s, gx;
    logic [63:0] f, p, m, a;
    logic [31:0] c0, c1;
    logic [7:0]  ch [4];
    int n, k, t;
    s = 64'(sh_cx) * (2 * 64'(px) + 1) + 64'(sh_cy) * (2 * 64'(py) + 1)
        + 2 * 64'(sh_off);
    gx = s >>> 1;
    if (sh_tile == lgps_pkg::TILE_REPEAT) begin
      f = 64'(gx) & 64'hFFFF;
    end else if (sh_tile == lgps_pkg::TILE_MIRROR) begin
      m = 64'(gx) & 64'h1FFFF;
      f = (m > 65536) ? 131072 - m : m;
    end else begin
      f = (gx < 0) ? 0 : (gx > 65536) ? 65536 : 64'(gx);
    end
    n = (sh_count == 0) ? 1 : (sh_count > lgps_pkg::MAX_STOPS) ? lgps_pkg::MAX_STOPS
                                                                : int'(sh_count);
    p = f * 64'(n - 1);
    k = int'(p >> 16);
    t = int'(p & 64'hFFFF);
    if (k >= n - 1) begin
      k = n - 1;
      t = 0;
    end
    c0 = stops[k];
    c1 = stops[(k + 1 < n) ? k + 1 : k];
    for (int i = 0; i < 4; i++) begin
      logic signed [63:0] v0, v1;
      v0 = 64'(c0[24-8*i +: 8]);
      v1 = 64'(c1[24-8*i +: 8]);
      if (i == 0) a = 64'(v0 * 65536 + 64'(t) * (v1 - v0));
      else ch[i] = premul(64'(v0 * 65536 + 64'(t) * (v1 - v0)), a);
    end
    ch[0] = 8'((a + 32768) >> 16);
    return {ch[0], ch[1], ch[2], ch[3]};
  endfunction

  task automatic idle_gap();
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // hold the transfer until accepted; a typed expectation replaces the predictor
  task automatic send(shade_req_t r, bit has_want = 1'b0, logic [31:0] want = '0);
    idle_gap();
    in_tuser  <= r.op;
    in_tdata  <= {4'd0, r.argb[7:0], r.argb[15:8], r.argb[23:16], r.argb[31:24],
                  r.idx, r.py, r.px};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (r.op == lgps_pkg::OP_WRITE) begin
      stops[r.idx] = r.argb;
    end else if (has_want) begin
      pixel_q = {pixel_q, want};
    end else begin
      pixel_q = {pixel_q, shade_pixel(r.px, r.py)};
    end
    @(negedge clk);
  endtask

  task automatic write_reg(lgps_pkg::cfg_idx_t i, logic [31:0] d);
    cfg_index <= i;
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (i)
      lgps_pkg::CFG_COEF_X:      sh_cx = d;
      lgps_pkg::CFG_COEF_Y:      sh_cy = d;
      lgps_pkg::CFG_COEF_OFFSET: sh_off = d;
      lgps_pkg::CFG_TILE_MODE:   sh_tile = d[1:0];
      default:                   sh_count = d[4:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  // receiver: random stall bursts, checks each transfer
  always @(negedge clk) begin
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        $error("pixel_argb unexpected: %h", out_tdata);
        failures++;
      end else begin
        logic [31:0] want;
        want = pixel_q.pop_front();
        if (out_tdata !== want) begin
          $error("pixel_argb expected %h actual %h", want, out_tdata);
          failures++;
        end
      end
    end
    if (cycle > MAX_CYCLE) begin
      $display("linear_gradient_pixel_shader_core_tb NOT OK");
      $finish;
    end
  end

  function automatic shade_req_t rnd_write(int hi);
    shade_req_t r;
    r.op = lgps_pkg::OP_WRITE;
    r.px = 12'($urandom);
    r.py = 12'($urandom);
    r.idx = 4'($urandom_range(0, hi));
    r.argb = $urandom;
    return r;
  endfunction

  function automatic shade_req_t rnd_shade();
    shade_req_t r;
    r.op = lgps_pkg::OP_SHADE;
    r.px = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h0)
                                       : 12'($urandom);
    r.py = 12'($urandom);
    r.idx = 4'($urandom);
    r.argb = $urandom;
    return r;
  endfunction

  // directed rows: loads of the extremes, interleaved with shades at and near the corners;
  // expect is typed only where it is obvious, else a zero has_want means predictor only
  typedef struct {
    shade_req_t req;
    bit         has_want;
    logic [31:0] want;
  } row_t;

  row_t rows [8] = '{
    '{'{lgps_pkg::OP_WRITE, 12'd0, 12'd0, 4'd0, 32'hFF00_0000}, 0, 32'h0},
    '{'{lgps_pkg::OP_WRITE, 12'd0, 12'd0, 4'd1, 32'hFFFF_FFFF}, 0, 32'h0},
    '{'{lgps_pkg::OP_SHADE, 12'd0, 12'd0, 4'd0, 32'h0}, 0, 32'h0},
    '{'{lgps_pkg::OP_SHADE, 12'hFFF, 12'hFFF, 4'd0, 32'h0}, 1, 32'hFFFF_FFFF},
    '{'{lgps_pkg::OP_SHADE, 12'd1, 12'd0, 4'd0, 32'h0}, 1, 32'hFFFF_FFFF},
    '{'{lgps_pkg::OP_WRITE, 12'hFFF, 12'hFFF, 4'd15, 32'h00FF_FFFF}, 0, 32'h0},
    '{'{lgps_pkg::OP_WRITE, 12'd0, 12'd0, 4'd2, 32'h80FF_8000}, 0, 32'h0},
    '{'{lgps_pkg::OP_SHADE, 12'd0, 12'hFFF, 4'd15, 32'hFFFF_FFFF}, 0, 32'h0}
  };

  initial begin
    for (int i = 0; i < lgps_pkg::MAX_STOPS; i++) stops[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      send(rows[i].req, rows[i].has_want, rows[i].want);
    end
    settle();
    // fill every stop so no shade reads an empty entry
    for (int i = 0; i < lgps_pkg::MAX_STOPS; i++) begin
      shade_req_t r;
      r = rnd_write(lgps_pkg::MAX_STOPS - 1);
      r.idx = 4'(i);
      send(r);
    end
    send('{lgps_pkg::OP_WRITE, 12'd0, 12'd0, 4'd15, 32'h0000_0000});
    send('{lgps_pkg::OP_SHADE, 12'd5, 12'd7, 4'd0, 32'h0});
    settle();

    // walk tile modes and counts including zero, one, full and oversize
    for (int ph = 0; ph < 12; ph++) begin
      logic [4:0] cnt;
      cnt = (ph == 0) ? 5'd0 : (ph == 1) ? 5'd1 : (ph == 2) ? 5'd16 :
            (ph == 3) ? 5'd31 : 5'($urandom_range(1, 17));
      write_reg(lgps_pkg::CFG_TILE_MODE, 32'(ph % 4));
      write_reg(lgps_pkg::CFG_COLOR_COUNT, 32'(cnt));
      case (ph)
        0: write_reg(lgps_pkg::CFG_COEF_X, 32'h8000_0000);
        1: write_reg(lgps_pkg::CFG_COEF_X, 32'h7FFF_FFFF);
        2: write_reg(lgps_pkg::CFG_COEF_Y, 32'h8000_0000);
        3: write_reg(lgps_pkg::CFG_COEF_Y, 32'h7FFF_FFFF);
        4: write_reg(lgps_pkg::CFG_COEF_OFFSET, 32'h8000_0000);
        5: write_reg(lgps_pkg::CFG_COEF_OFFSET, 32'h7FFF_FFFF);
        default: begin
          write_reg(lgps_pkg::CFG_COEF_X, 32'($signed($urandom_range(0, 400)) - 200));
          write_reg(lgps_pkg::CFG_COEF_Y, ($urandom_range(0, 3) == 0) ? $urandom
                                 : 32'($signed($urandom_range(0, 400)) - 200));
          write_reg(lgps_pkg::CFG_COEF_OFFSET,
                    32'($signed($urandom_range(0, 300000)) - 100000));
        end
      endcase
      if (ph == 10) no_idle = 1'b1;
      for (int j = 0; j < N_RANDOM / 12; j++) begin
        if ($urandom_range(0, 9) == 0) send(rnd_write(15));
        else send(rnd_shade());
      end
      settle();
    end

    if (failures == 0) begin
      $display("linear_gradient_pixel_shader_core_tb OK");
    end else begin
      $display("linear_gradient_pixel_shader_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lgps_pkg.sv
rtl/lgps_ram.sv
rtl/lgps_front.sv
rtl/lgps_queue.sv
rtl/lgps_back.sv
rtl/linear_gradient_pixel_shader_core.sv
test/linear_gradient_pixel_shader_core_tb.sv
